// ===== design/rotation_matrix_to_quaternion_assert.svh =====
// Assertion macros for the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Checked only outside reset.
`define RMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define RMQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/rmq_pkg.sv =====
package rmq_pkg;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] rot_scalar;
    logic signed [15:0] rot_e1e2;
    logic signed [15:0] rot_e2e3;
    logic signed [15:0] rot_e3e1;
    logic               degenerate;
  } rot_t;

  localparam int unsigned ThrW    = 15;
  localparam int unsigned LanesN  = 4;
  localparam int unsigned MagW    = 19;            // component magnitude after scaling
  localparam int unsigned SqW     = 2 * MagW;
  localparam int unsigned SumW    = SqW + 2;
  localparam int unsigned RadW    = SumW + 16;     // radicand: sum of squares times 2^16
  localparam int unsigned RootW   = RadW / 2;
  localparam int unsigned RemW    = RadW + 2;
  localparam int unsigned QuoW    = 16;
  localparam int unsigned OqDepth = 64;
  localparam int unsigned OqAw    = 6;
  localparam int unsigned OqCntW  = OqAw + 1;
  localparam int unsigned CredW   = OqAw + 1;

endpackage

// ===== design/rmq_front.sv =====
module rmq_front #(
  parameter int unsigned FracBits = 14,
  parameter int unsigned CompW    = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rmq_pkg::ThrW-1:0]      thr_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rmq_pkg::mat_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rmq_pkg::LanesN*CompW-1:0] out_data_o
);
  import rmq_pkg::*;

  logic signed [CompW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [CompW-1:0] one, t, thr, d0, d1, d2;
  logic signed [CompW-1:0] w, x, y, z;
  logic [LanesN*CompW-1:0] data_d, data_q;
  logic valid_q, take;

  assign e00 = CompW'(in_data_i.m00);
  assign e01 = CompW'(in_data_i.m01);
  assign e02 = CompW'(in_data_i.m02);
  assign e10 = CompW'(in_data_i.m10);
  assign e11 = CompW'(in_data_i.m11);
  assign e12 = CompW'(in_data_i.m12);
  assign e20 = CompW'(in_data_i.m20);
  assign e21 = CompW'(in_data_i.m21);
  assign e22 = CompW'(in_data_i.m22);

  assign one = CompW'(1) <<< FracBits;
  assign t   = e00 + e11 + e22 + one;
  assign thr = $signed(CompW'(thr_i));
  assign d0  = one + e00 - e11 - e22;
  assign d1  = one + e11 - e00 - e22;
  assign d2  = one + e22 - e00 - e11;

  // Pick the branch; diagonal terms of a non-rotation may go negative, clamp them.
  always_comb begin
    if (t > thr) begin
      w = t;         x = e21 - e12; y = e02 - e20; z = e10 - e01;
    end else if (in_data_i.m00 > in_data_i.m11 && in_data_i.m00 > in_data_i.m22) begin
      w = e21 - e12; x = d0[CompW-1] ? '0 : d0; y = e01 + e10; z = e02 + e20;
    end else if (in_data_i.m11 > in_data_i.m22) begin
      w = e02 - e20; x = e01 + e10; y = d1[CompW-1] ? '0 : d1; z = e12 + e21;
    end else begin
      w = e10 - e01; x = e02 + e20; y = e12 + e21; z = d2[CompW-1] ? '0 : d2;
    end
    data_d = {w, -z, -x, -y};
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== design/rmq_fifo.sv =====
module rmq_fifo #(
  parameter int unsigned Width = 80
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);
  import rmq_pkg::*;

  logic [Width-1:0] slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/rmq_back.sv =====
module rmq_back #(
  parameter int unsigned FracBits = 14,
  parameter int unsigned CompW    = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [rmq_pkg::LanesN*CompW-1:0] in_data_i,
  output logic                             out_valid_o,
  output rmq_pkg::rot_t                    out_data_o
);
  import rmq_pkg::*;

  localparam int unsigned MW    = CompW - 1;
  localparam int unsigned ShMax = (MW > MagW) ? MW - MagW : 0;
  localparam int unsigned ShW   = (ShMax > 0) ? $clog2(ShMax + 1) : 1;
  localparam int unsigned NumW  = FracBits + 28;
  localparam int unsigned DW    = (NumW > RootW + QuoW + 1) ? NumW : RootW + QuoW + 1;

  // ---- scaling: magnitudes, common shift ----
  logic [MW-1:0]   mag_in [LanesN];
  logic [MW-1:0]   mag_or;
  logic [ShW-1:0]  sh_in;
  logic [MW-1:0]   mag_a_q [LanesN];
  logic [LanesN-1:0] neg_a_q, neg_b_q, neg_c_q, neg_d_q;
  logic [ShW-1:0]  sh_a_q;
  logic            v_a_q, v_b_q, v_c_q, v_d_q;
  logic [MagW-1:0] mag_b_q [LanesN];
  logic [MagW-1:0] mag_c_q [LanesN];
  logic [SqW-1:0]  sq_c_q  [LanesN];
  logic [MagW-1:0] mag_d_q [LanesN];
  logic [SumW-1:0] sum_d_q;

  always_comb begin
    mag_or = '0;
    for (int l = 0; l < LanesN; l++) begin
      logic [CompW-1:0] c;
      c = in_data_i[(LanesN-1-l)*CompW +: CompW];
      mag_in[l] = MW'(c[CompW-1] ? (~c + 1'b1) : c);
      mag_or = mag_or | mag_in[l];
    end
    sh_in = '0;
    for (int b = MagW; b < MW; b++) begin
      if (mag_or[b]) sh_in = ShW'(b - MagW + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
    end else begin
      v_a_q <= in_valid_i;
      v_b_q <= v_a_q;
      v_c_q <= v_b_q;
      v_d_q <= v_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LanesN; l++) begin
      mag_a_q[l] <= mag_in[l];
      neg_a_q[l] <= in_data_i[(LanesN-l)*CompW-1];
      mag_b_q[l] <= MagW'(mag_a_q[l] >> sh_a_q);
      mag_c_q[l] <= mag_b_q[l];
      sq_c_q[l]  <= SqW'(mag_b_q[l]) * SqW'(mag_b_q[l]);
      mag_d_q[l] <= mag_c_q[l];
    end
    sh_a_q  <= sh_in;
    neg_b_q <= neg_a_q;
    neg_c_q <= neg_b_q;
    neg_d_q <= neg_c_q;
    sum_d_q <= SumW'(sq_c_q[0]) + SumW'(sq_c_q[1]) + SumW'(sq_c_q[2]) + SumW'(sq_c_q[3]);
  end

  // ---- square root, one result bit per stage ----
  logic [RemW-1:0]   rem_s  [RootW+1];
  logic [RootW-1:0]  root_s [RootW+1];
  logic [MagW-1:0]   mag_s  [RootW+1][LanesN];
  logic [LanesN-1:0] neg_s  [RootW+1];
  logic              dg_s   [RootW+1];
  logic              v_s    [RootW+1];

  assign rem_s[0]  = RemW'({sum_d_q, 16'b0});
  assign root_s[0] = '0;
  assign mag_s[0]  = mag_d_q;
  assign neg_s[0]  = neg_d_q;
  assign dg_s[0]   = sum_d_q == '0;
  assign v_s[0]    = v_d_q;

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    localparam int unsigned Bit = RootW - 1 - k;
    logic [RemW-1:0] trial;
    assign trial = (RemW'(root_s[k]) << (Bit + 1)) + (RemW'(1) << (2 * Bit));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem_s[k] >= trial) begin
        rem_s[k+1]  <= rem_s[k] - trial;
        root_s[k+1] <= root_s[k] | (RootW'(1) << Bit);
      end else begin
        rem_s[k+1]  <= rem_s[k];
        root_s[k+1] <= root_s[k];
      end
      mag_s[k+1] <= mag_s[k];
      neg_s[k+1] <= neg_s[k];
      dg_s[k+1]  <= dg_s[k];
    end
  end

  // ---- divide each lane by the root, one quotient bit per stage ----
  logic [DW-1:0]     r_s   [QuoW+1][LanesN];
  logic [QuoW-1:0]   q_s   [QuoW+1][LanesN];
  logic [LanesN-1:0] ovf_s [QuoW+1];
  logic [RootW-1:0]  n_s   [QuoW+1];
  logic [LanesN-1:0] sgn_s [QuoW+1];
  logic              dz_s  [QuoW+1];
  logic              vq_s  [QuoW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_s[0] <= 1'b0;
    end else begin
      vq_s[0] <= v_s[RootW];
    end
  end

  // Add half the divisor so that the quotient rounds half away from zero.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LanesN; l++) begin
      logic [DW-1:0] num;
      num = (DW'(mag_s[RootW][l]) << (FracBits + 8)) + DW'(root_s[RootW] >> 1);
      r_s[0][l]    <= num;
      q_s[0][l]    <= '0;
      ovf_s[0][l]  <= num >= (DW'(root_s[RootW]) << QuoW);
    end
    n_s[0]   <= root_s[RootW];
    sgn_s[0] <= neg_s[RootW];
    dz_s[0]  <= dg_s[RootW];
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    localparam int unsigned Bit = QuoW - 1 - k;
    logic [DW-1:0] den;
    assign den = DW'(n_s[k]) << Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq_s[k+1] <= 1'b0;
      end else begin
        vq_s[k+1] <= vq_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < LanesN; l++) begin
        if (r_s[k][l] >= den) begin
          r_s[k+1][l] <= r_s[k][l] - den;
          q_s[k+1][l] <= q_s[k][l] | (QuoW'(1) << Bit);
        end else begin
          r_s[k+1][l] <= r_s[k][l];
          q_s[k+1][l] <= q_s[k][l];
        end
      end
      ovf_s[k+1] <= ovf_s[k];
      n_s[k+1]   <= n_s[k];
      sgn_s[k+1] <= sgn_s[k];
      dz_s[k+1]  <= dz_s[k];
    end
  end

  // ---- sign, saturate, degenerate ----
  logic signed [15:0] res [LanesN];
  rot_t out_q;
  logic out_v_q;

  always_comb begin
    for (int l = 0; l < LanesN; l++) begin
      logic [QuoW-1:0] q;
      q = q_s[QuoW][l];
      if (dz_s[QuoW]) begin
        res[l] = '0;
      end else if (sgn_s[QuoW][l]) begin
        res[l] = (ovf_s[QuoW][l] || q > 16'd32768) ? 16'sh8000 : $signed(-q);
      end else begin
        res[l] = (ovf_s[QuoW][l] || q > 16'd32767) ? 16'sh7fff : $signed(q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= vq_s[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.rot_scalar <= res[0];
    out_q.rot_e1e2   <= res[1];
    out_q.rot_e2e3   <= res[2];
    out_q.rot_e3e1   <= res[3];
    out_q.degenerate <= dz_s[QuoW];
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/rmq_outq.sv =====
module rmq_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  rmq_pkg::rot_t wr_data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output rmq_pkg::rot_t data_o
);
  import rmq_pkg::*;

  rot_t              mem [OqDepth];
  rot_t              head_q;
  logic              head_v_q;
  logic [OqAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OqCntW-1:0] cnt_q;
  logic head_take, load_mem, to_head, wr_mem;

  // Refill the head from the memory first; bypass only when nothing is stored.
  assign head_take = !head_v_q || pop_i;
  assign load_mem  = head_take && cnt_q != '0;
  assign to_head   = wr_i && head_take && cnt_q == '0;
  assign wr_mem    = wr_i && !to_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (load_mem || to_head) begin
        head_v_q <= 1'b1;
      end else if (pop_i) begin
        head_v_q <= 1'b0;
      end
      if (wr_mem)   wr_ptr_q <= wr_ptr_q + 1'b1;
      if (load_mem) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + OqCntW'(wr_mem) - OqCntW'(load_mem);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_mem) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
    if (load_mem) begin
      head_q <= mem[rd_ptr_q];
    end else if (to_head) begin
      head_q <= wr_data_i;
    end
  end

  assign empty_o = !head_v_q;
  assign data_o  = head_q;

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
// Converts one 3x3 rotation matrix (signed Q2.FRAC_BITS entries) per word into
// a unit rotor (scalar, e1e2, e2e3, e3e1) by Shepperd's method, taking one
// matrix per clock in steady state while full stays low. A matrix passes from push
// to the head of the result queue through one classify register, a two-word queue,
// then a 50-stage pipeline dominated by a 28-stage square root and a 16-stage
// divider per component. Up to 65 results are held when pop is slow; push stalls
// (full) only once that space is committed. The user writes trace_threshold through
// cfg_valid_i / cfg_ready_o only while the block is idle; the block does not enforce it.
`include "rotation_matrix_to_quaternion_assert.svh"

module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [rmq_pkg::ThrW-1:0] cfg_data_i,
  input  logic                     push,
  output logic                     full,
  input  rmq_pkg::mat_t            in_data_i,
  output logic                     empty,
  input  logic                     pop,
  output rmq_pkg::rot_t            out_data_o
);
  import rmq_pkg::*;

  localparam int unsigned CompW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int unsigned Cap   = OqDepth + 1;

  logic [ThrW-1:0] thr_q;
  logic front_ready, front_valid, mid_full, mid_valid;
  logic [LanesN*CompW-1:0] front_data, mid_data;
  logic back_valid, issue, pop_ok;
  rot_t back_data;
  logic [CredW-1:0] inflight_q;
  logic out_zero;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  rmq_front #(.FracBits(FRAC_BITS), .CompW(CompW)) u_front (
    .clk_i, .rst_ni,
    .thr_i       (thr_q),
    .in_valid_i  (push),
    .in_ready_o  (front_ready),
    .in_data_i   (in_data_i),
    .out_valid_o (front_valid),
    .out_ready_i (!mid_full),
    .out_data_o  (front_data)
  );

  assign full = !front_ready;

  rmq_fifo #(.Width(LanesN*CompW)) u_mid (
    .clk_i, .rst_ni,
    .push_i  (front_valid),
    .data_i  (front_data),
    .full_o  (mid_full),
    .pop_i   (issue),
    .valid_o (mid_valid),
    .data_o  (mid_data)
  );

  // Issue only with a result slot reserved; the pipeline never stalls.
  assign issue  = mid_valid && inflight_q < CredW'(Cap);
  assign pop_ok = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CredW'(issue) - CredW'(pop_ok);
    end
  end

  rmq_back #(.FracBits(FRAC_BITS), .CompW(CompW)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i  (issue),
    .in_data_i   (mid_data),
    .out_valid_o (back_valid),
    .out_data_o  (back_data)
  );

  rmq_outq u_outq (
    .clk_i, .rst_ni,
    .wr_i      (back_valid),
    .wr_data_i (back_data),
    .pop_i     (pop_ok),
    .empty_o   (empty),
    .data_o    (out_data_o)
  );

  assign out_zero = {out_data_o.rot_scalar, out_data_o.rot_e1e2,
                     out_data_o.rot_e2e3, out_data_o.rot_e3e1} == '0;

  `RMQ_ASSERT(a_credit_bound, inflight_q <= CredW'(Cap), "more words in flight than slots")
  `RMQ_ASSERT(a_pop_has_credit, pop_ok |-> inflight_q != '0, "result popped with none in flight")
  `RMQ_ASSERT(a_degenerate_zero, (!empty && out_data_o.degenerate) |-> out_zero, "degenerate not zero")
  `RMQ_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (empty && inflight_q == '0), "state not cleared")

endmodule

// ===== tb/tb_rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int unsigned FracBits   = 14;
  localparam int unsigned DrainWait  = 120;
  localparam int unsigned StallLimit = 20000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [ThrW-1:0] cfg_data_i = '0;
  logic            push = 1'b0;
  logic            full;
  mat_t            in_data_i = '0;
  logic            empty;
  logic            pop = 1'b0;
  rot_t            out_data_o;

  rot_t        rot_expected_q[$];
  logic [14:0] trace_thr = '0;
  int unsigned push_idle_pct = 0;
  int unsigned pop_idle_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FracBits)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic rot_t matrix_to_rotor(mat_t m, logic [14:0] thr);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint one, t, w, x, y, z, d;
    longint comp[4];
    longint unsigned mag[4];
    longint unsigned maxm, sum, n, q;
    logic neg[4];
    logic signed [15:0] r[4];
    rot_t res;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    one = 64'sd1 <<< FracBits;
    t = a00 + a11 + a22 + one;
    if (t > longint'(thr)) begin
      w = t; x = a21 - a12; y = a02 - a20; z = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      d = one + a00 - a11 - a22;
      if (d < 0) d = 0;
      w = a21 - a12; x = d; y = a01 + a10; z = a02 + a20;
    end else if (a11 > a22) begin
      d = one + a11 - a00 - a22;
      if (d < 0) d = 0;
      w = a02 - a20; x = a01 + a10; y = d; z = a12 + a21;
    end else begin
      d = one + a22 - a00 - a11;
      if (d < 0) d = 0;
      w = a10 - a01; x = a02 + a20; y = a12 + a21; z = d;
    end
    comp[0] = w; comp[1] = -z; comp[2] = -x; comp[3] = -y;
    maxm = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = comp[i] < 0;
      mag[i] = neg[i] ? -comp[i] : comp[i];
      if (mag[i] > maxm) maxm = mag[i];
    end
    while (maxm >= (64'd1 << 19)) begin
      maxm >>= 1;
      for (int i = 0; i < 4; i++) mag[i] >>= 1;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
    res = '0;
    if (sum == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    n = int_sqrt(sum << 16);
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << (FracBits + 8)) + (n >> 1)) / n;
      if (neg[i]) r[i] = (q > 32768) ? 16'sh8000 : 16'(-longint'(q));
      else r[i] = (q > 32767) ? 16'sh7fff : 16'(q);
    end
    res.rot_scalar = r[0];
    res.rot_e1e2   = r[1];
    res.rot_e2e3   = r[2];
    res.rot_e3e1   = r[3];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Result checker and receiver idling.
  always @(posedge clk_i) begin
    rot_t exp_w;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (rot_expected_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          exp_w = rot_expected_q.pop_front();
          if (out_data_o.rot_scalar !== exp_w.rot_scalar)
            report_mismatch("rot_scalar", out_data_o.rot_scalar, exp_w.rot_scalar);
          if (out_data_o.rot_e1e2 !== exp_w.rot_e1e2)
            report_mismatch("rot_e1e2", out_data_o.rot_e1e2, exp_w.rot_e1e2);
          if (out_data_o.rot_e2e3 !== exp_w.rot_e2e3)
            report_mismatch("rot_e2e3", out_data_o.rot_e2e3, exp_w.rot_e2e3);
          if (out_data_o.rot_e3e1 !== exp_w.rot_e3e1)
            report_mismatch("rot_e3e1", out_data_o.rot_e3e1, exp_w.rot_e3e1);
          if (out_data_o.degenerate !== exp_w.degenerate)
            report_mismatch("degenerate", out_data_o.degenerate, exp_w.degenerate);
        end
      end
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("rotation_matrix_to_quaternion test failed");
      $finish;
    end
  end

  // Keep push high across back-to-back words; drop it only while idling.
  task automatic send_matrix(mat_t m);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= m;
    do @(posedge clk_i); while (full);
    rot_expected_q.push_back(matrix_to_rotor(m, trace_thr));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (rot_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [14:0] thr);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    trace_thr = thr;
  endtask

  function automatic mat_t diag_matrix(int d0, int d1, int d2);
    mat_t m;
    m = '0;
    m.m00 = 16'(d0); m.m11 = 16'(d1); m.m22 = 16'(d2);
    return m;
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    m = mat_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return m;
  endfunction

  // Rotation about one axis by a random angle, plus noise.
  function automatic mat_t near_rotation();
    mat_t m;
    int ax;
    int c;
    int s;
    ax = $urandom_range(2);
    c = $signed(16'($urandom_range(32767))) % 16385;
    if ($urandom_range(1)) c = -c;
    s = int'(int_sqrt(64'(16384 * 16384 - c * c)));
    if ($urandom_range(1)) s = -s;
    m = diag_matrix(16384, 16384, 16384);
    case (ax)
      0: begin m.m11 = 16'(c); m.m22 = 16'(c); m.m12 = 16'(-s); m.m21 = 16'(s); end
      1: begin m.m00 = 16'(c); m.m22 = 16'(c); m.m02 = 16'(s); m.m20 = 16'(-s); end
      default: begin m.m00 = 16'(c); m.m11 = 16'(c); m.m01 = 16'(-s); m.m10 = 16'(s); end
    endcase
    m.m00 = m.m00 + 16'($signed($urandom_range(8)) - 4);
    m.m01 = m.m01 + 16'($signed($urandom_range(8)) - 4);
    m.m21 = m.m21 + 16'($signed($urandom_range(8)) - 4);
    return m;
  endfunction

  task automatic test_directed();
    mat_t m;
    send_matrix(diag_matrix(16384, 16384, 16384));
    send_matrix(diag_matrix(16384, -16384, -16384));
    send_matrix(diag_matrix(-16384, 16384, -16384));
    send_matrix(diag_matrix(-16384, -16384, 16384));
    // non-rotation matrices with extreme entries
    send_matrix(diag_matrix(-16384, -16384, -16384));
    send_matrix(diag_matrix(-32768, -32768, -32768));
    send_matrix(diag_matrix(32767, 32767, 32767));
    send_matrix(diag_matrix(-32768, 32767, -32768));
    send_matrix(diag_matrix(0, 0, -16384));
    m = '1;
    send_matrix(m);
    m = {9{16'sh8000}};
    send_matrix(m);
    m = {9{16'sh7fff}};
    send_matrix(m);
    m = diag_matrix(-32768, -32768, -32768);
    m.m01 = 16'sh7fff; m.m10 = 16'sh8000; m.m12 = 16'sh8000; m.m21 = 16'sh7fff;
    send_matrix(m);
    m = diag_matrix(-16384, -16384, -16384);
    m.m02 = 16'sh7fff; m.m20 = 16'sh7fff;
    send_matrix(m);
    m = '0;
    m.m11 = 16'shc000;
    send_matrix(m);
    repeat (6) send_matrix(near_rotation());
  endtask

  task automatic test_random(int unsigned cnt);
    for (int unsigned i = 0; i < cnt; i++) begin
      if ($urandom_range(9) < 7) send_matrix(near_rotation());
      else send_matrix(random_matrix());
      // hold off until the pipeline has drained, once per phase
      if (i == cnt / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    write_threshold(15'd16384);
    test_directed();
    push_idle_pct = 19;
    pop_idle_pct = 53;
    test_random(550);
    wait_drained();
    write_threshold(15'($urandom_range(16384)));
    push_idle_pct = 53;
    pop_idle_pct = 19;
    test_random(550);
    wait_drained();
    write_threshold(15'd0);
    push_idle_pct = 0;
    pop_idle_pct = 0;
    test_random(560);
    wait_drained();
    if (mismatch_cnt == 0 && rot_expected_q.size() == 0) begin
      $display("rotation_matrix_to_quaternion test passed");
    end else begin
      $display("rotation_matrix_to_quaternion test failed");
    end
    $finish;
  end

endmodule
